[hw/rtl/tape_language_processor_macros.svh]
// Assertion helpers for the tape language processor checker
`ifndef TAPE_LANGUAGE_PROCESSOR_MACROS_SVH
`define TAPE_LANGUAGE_PROCESSOR_MACROS_SVH

// Same-cycle implication, disabled during reset
`define TLP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define TLP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/tlp_pkg.sv]
package tlp_pkg;

    localparam int TAPE_DEPTH_DEF    = 32768;
    localparam int PROGRAM_DEPTH_DEF = 4096;
    localparam int NEST_DEPTH_DEF    = 64;

    localparam int KIND_W   = 2;
    localparam int SYM_W    = 8;
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 13;
    localparam int CMD_W    = 3;

    // item kinds
    localparam logic [KIND_W-1:0] K_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] K_START  = 2'd1;
    localparam logic [KIND_W-1:0] K_STEP   = 2'd2;
    localparam logic [KIND_W-1:0] K_SUPPLY = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BYTE    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WAIT    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HALT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BRACKET = 3'd4;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd5;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_START
    } t_state;

    typedef enum logic [1:0] {
        M_LOAD,
        M_RUN,
        M_WAIT,
        M_HALT
    } t_mode;

    typedef enum logic [CMD_W-1:0] {
        C_LEFT,
        C_RIGHT,
        C_OUT,
        C_IN,
        C_INC,
        C_DEC,
        C_OPEN,
        C_CLOSE
    } t_cmd;

    typedef struct packed {
        logic hit;
        t_cmd code;
    } t_decode;

    // Map a program character to its command code
    function automatic t_decode decode_symbol(logic [SYM_W-1:0] s);
        t_decode d;
        d.hit  = 1'b1;
        d.code = C_LEFT;
        case (s)
            8'h3C: d.code = C_LEFT;
            8'h3E: d.code = C_RIGHT;
            8'h2E: d.code = C_OUT;
            8'h2C: d.code = C_IN;
            8'h2B: d.code = C_INC;
            8'h2D: d.code = C_DEC;
            8'h5B: d.code = C_OPEN;
            8'h5D: d.code = C_CLOSE;
            default: d.hit = 1'b0;
        endcase
        return d;
    endfunction

endpackage

[hw/rtl/tlp_in_if.sv]
interface tlp_in_if;
    import tlp_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;

    modport source (output valid, output kind, output symbol, input ready);
    modport sink   (input valid, input kind, input symbol, output ready);
endinterface

[hw/rtl/tlp_out_if.sv]
interface tlp_out_if;
    import tlp_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic [POS_W-1:0]    position;

    modport source (output valid, output status, output out_byte, output position, input ready);
    modport sink   (input valid, input status, input out_byte, input position, output ready);
endinterface

[hw/rtl/tape_language_processor.sv]
// Tape language processor. Every item gives exactly one result word. Load, step and
// input-byte items first do the synchronous read of program store, jump table,
// bracket stack and tape cell, then modify and write back. A load of a ']' that
// closes a '[' also passes through S_LINK, as the second jump table entry needs the
// single write port of that memory. A start item finishes in S_START, after a clearing
// pass over the whole tape (S_CLEAR) when the tape was written since it was last
// cleared. After reset the block sweeps the whole tape before the first item is
// accepted. A finished result waits in an output register; the next item is accepted
// but finishes only once that register is free.
module tape_language_processor #(
    parameter int TAPE_DEPTH    = tlp_pkg::TAPE_DEPTH_DEF,
    parameter int PROGRAM_DEPTH = tlp_pkg::PROGRAM_DEPTH_DEF,
    parameter int NEST_DEPTH    = tlp_pkg::NEST_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlp_in_if.sink    i_in,
    tlp_out_if.source o_out
);
    import tlp_pkg::*;

    localparam int TW = $clog2(TAPE_DEPTH);
    localparam int AW = $clog2(PROGRAM_DEPTH);
    localparam int PW = AW + 1;
    localparam int SW = $clog2(NEST_DEPTH);
    localparam int LW = SW + 1;

    t_state              r_state, n_state;
    t_mode               r_mode, n_mode;
    logic [PW-1:0]       r_len, n_len;
    logic [PW-1:0]       r_pc, n_pc;
    logic [TW-1:0]       r_dp, n_dp;
    logic [LW-1:0]       r_level, n_level;
    logic                r_fault, n_fault;
    logic                r_dirty, n_dirty;
    logic [TW-1:0]       r_clr_cnt, n_clr_cnt;
    logic                r_start_pend, n_start_pend;
    logic [KIND_W-1:0]   r_kind;
    logic [SYM_W-1:0]    r_sym;
    logic [AW-1:0]       r_link_open, n_link_open;
    logic [AW-1:0]       r_link_at, n_link_at;
    logic                r_ovalid;
    logic [STATUS_W-1:0] r_status;
    logic [BYTE_W-1:0]   r_obyte;
    logic [POS_W-1:0]    r_pos;

    logic                res_load;
    logic [STATUS_W-1:0] res_status;
    logic [BYTE_W-1:0]   res_byte;
    logic                out_free;
    logic                in_take;
    logic                last_clear;
    logic                is_link;
    t_decode             dec;
    logic [LW-1:0]       level_m1;

    logic                prog_we;
    logic [CMD_W-1:0]    prog_wdata, prog_rdata;
    logic                jump_we;
    logic [AW-1:0]       jump_waddr, jump_wdata, jump_rdata;
    logic                stack_we;
    logic [AW-1:0]       stack_rdata;
    logic                tape_we;
    logic [TW-1:0]       tape_waddr;
    logic [BYTE_W-1:0]   tape_wdata, tape_rdata;

    assign out_free   = !r_ovalid || o_out.ready;
    assign in_take    = (r_state == S_IDLE) && i_in.valid;
    assign last_clear = (r_clr_cnt == TW'(TAPE_DEPTH - 1));
    assign dec        = decode_symbol(r_sym);
    assign level_m1   = r_level - LW'(1);
    assign is_link    = (r_kind == K_LOAD) && dec.hit && (r_len < PW'(PROGRAM_DEPTH))
                        && (dec.code == C_CLOSE) && (r_level != '0);

    // memories
    tlp_ram #(.WIDTH(CMD_W), .DEPTH(PROGRAM_DEPTH)) u_prog (
        .i_clk(i_clk), .i_we(prog_we), .i_waddr(r_len[AW-1:0]), .i_wdata(prog_wdata),
        .i_raddr(r_pc[AW-1:0]), .o_rdata(prog_rdata)
    );
    tlp_ram #(.WIDTH(AW), .DEPTH(PROGRAM_DEPTH)) u_jump (
        .i_clk(i_clk), .i_we(jump_we), .i_waddr(jump_waddr), .i_wdata(jump_wdata),
        .i_raddr(r_pc[AW-1:0]), .o_rdata(jump_rdata)
    );
    tlp_ram #(.WIDTH(AW), .DEPTH(NEST_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stack_we), .i_waddr(r_level[SW-1:0]),
        .i_wdata(r_len[AW-1:0]), .i_raddr(level_m1[SW-1:0]), .o_rdata(stack_rdata)
    );
    tlp_ram #(.WIDTH(BYTE_W), .DEPTH(TAPE_DEPTH)) u_tape (
        .i_clk(i_clk), .i_we(tape_we), .i_waddr(tape_waddr), .i_wdata(tape_wdata),
        .i_raddr(r_dp), .o_rdata(tape_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (last_clear) begin
                    n_state = r_start_pend ? S_START : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.kind == K_START) begin
                        n_state = r_dirty ? S_CLEAR : S_START;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = is_link ? S_LINK : S_IDLE;
                end
            end
            S_LINK, S_START: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_mode       = r_mode;
        n_len        = r_len;
        n_pc         = r_pc;
        n_dp         = r_dp;
        n_level      = r_level;
        n_fault      = r_fault;
        n_dirty      = r_dirty;
        n_clr_cnt    = r_clr_cnt;
        n_start_pend = r_start_pend;
        n_link_open  = r_link_open;
        n_link_at    = r_link_at;
        res_load     = 1'b0;
        res_status   = ST_OK;
        res_byte     = '0;
        prog_we      = 1'b0;
        prog_wdata   = dec.code;
        jump_we      = 1'b0;
        jump_waddr   = r_len[AW-1:0];
        jump_wdata   = stack_rdata;
        stack_we     = 1'b0;
        tape_we      = 1'b0;
        tape_waddr   = r_dp;
        tape_wdata   = '0;
        case (r_state)
            S_CLEAR: begin
                // sweep the tape with zeros
                tape_we    = 1'b1;
                tape_waddr = r_clr_cnt;
                n_clr_cnt  = r_clr_cnt + TW'(1);
                if (last_clear) begin
                    n_dirty = 1'b0;
                end
            end
            S_IDLE: begin
                if (in_take && i_in.kind == K_START) begin
                    n_dp         = '0;
                    n_pc         = '0;
                    n_clr_cnt    = '0;
                    n_start_pend = 1'b1;
                end
            end
            S_START: begin
                if (out_free) begin
                    res_load     = 1'b1;
                    n_start_pend = 1'b0;
                    if (r_fault || r_level != '0) begin
                        res_status = ST_BRACKET;
                        n_mode     = M_LOAD;
                    end else begin
                        n_mode = M_RUN;
                    end
                end
            end
            S_LINK: begin
                // back link of the opening bracket
                if (out_free) begin
                    jump_we    = 1'b1;
                    jump_waddr = r_link_open;
                    jump_wdata = r_link_at;
                    res_load   = 1'b1;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    res_load = !is_link;
                    case (r_kind)
                        K_LOAD: begin
                            if (dec.hit) begin
                                n_mode = M_LOAD;
                                if (r_len >= PW'(PROGRAM_DEPTH)) begin
                                    res_status = ST_FULL;
                                end else begin
                                    prog_we = 1'b1;
                                    n_len   = r_len + PW'(1);
                                    if (dec.code == C_OPEN) begin
                                        if (r_level < LW'(NEST_DEPTH)) begin
                                            stack_we = 1'b1;
                                            n_level  = r_level + LW'(1);
                                        end else begin
                                            n_fault    = 1'b1;
                                            res_status = ST_BRACKET;
                                        end
                                    end else if (dec.code == C_CLOSE) begin
                                        if (r_level != '0) begin
                                            n_level     = level_m1;
                                            jump_we     = 1'b1;
                                            n_link_open = stack_rdata;
                                            n_link_at   = r_len[AW-1:0];
                                        end else begin
                                            n_fault    = 1'b1;
                                            res_status = ST_BRACKET;
                                        end
                                    end
                                end
                            end
                        end
                        K_STEP: begin
                            if (r_mode == M_WAIT) begin
                                res_status = ST_WAIT;
                            end else if (r_mode != M_RUN) begin
                                res_status = ST_HALT;
                            end else if (r_pc >= r_len) begin
                                n_mode     = M_HALT;
                                res_status = ST_HALT;
                            end else begin
                                n_pc = r_pc + PW'(1);
                                case (t_cmd'(prog_rdata))
                                    C_LEFT: begin
                                        n_dp = (r_dp == '0) ? TW'(TAPE_DEPTH - 1)
                                                            : r_dp - TW'(1);
                                    end
                                    C_RIGHT: begin
                                        n_dp = (r_dp == TW'(TAPE_DEPTH - 1)) ? '0
                                                                             : r_dp + TW'(1);
                                    end
                                    C_OUT: begin
                                        res_status = ST_BYTE;
                                        res_byte   = tape_rdata;
                                    end
                                    C_IN: begin
                                        n_pc       = r_pc;
                                        n_mode     = M_WAIT;
                                        res_status = ST_WAIT;
                                    end
                                    C_INC: begin
                                        tape_we    = 1'b1;
                                        tape_wdata = tape_rdata + BYTE_W'(1);
                                        n_dirty    = 1'b1;
                                    end
                                    C_DEC: begin
                                        tape_we    = 1'b1;
                                        tape_wdata = tape_rdata - BYTE_W'(1);
                                        n_dirty    = 1'b1;
                                    end
                                    C_OPEN: begin
                                        if (tape_rdata == '0) begin
                                            n_pc = PW'(jump_rdata) + PW'(1);
                                        end
                                    end
                                    C_CLOSE: begin
                                        if (tape_rdata != '0) begin
                                            n_pc = PW'(jump_rdata) + PW'(1);
                                        end
                                    end
                                    default: n_pc = r_pc;
                                endcase
                            end
                        end
                        K_SUPPLY: begin
                            if (r_mode == M_WAIT && r_pc < PW'(PROGRAM_DEPTH)) begin
                                tape_we    = 1'b1;
                                tape_wdata = r_sym;
                                n_dirty    = 1'b1;
                                n_pc       = r_pc + PW'(1);
                                n_mode     = M_RUN;
                            end
                        end
                        default: res_status = ST_OK;
                    endcase
                end
            end
            default: res_load = 1'b0;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_in.ready     = (r_state == S_IDLE);
        o_out.valid    = r_ovalid;
        o_out.status   = r_status;
        o_out.out_byte = r_obyte;
        o_out.position = r_pos;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_mode       <= M_LOAD;
            r_len        <= '0;
            r_pc         <= '0;
            r_dp         <= '0;
            r_level      <= '0;
            r_fault      <= 1'b0;
            r_dirty      <= 1'b1;
            r_clr_cnt    <= '0;
            r_start_pend <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_len        <= n_len;
            r_pc         <= n_pc;
            r_dp         <= n_dp;
            r_level      <= n_level;
            r_fault      <= n_fault;
            r_dirty      <= n_dirty;
            r_clr_cnt    <= n_clr_cnt;
            r_start_pend <= n_start_pend;
            if (res_load) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_kind <= i_in.kind;
            r_sym  <= i_in.symbol;
        end
        r_link_open <= n_link_open;
        r_link_at   <= n_link_at;
        if (res_load) begin
            r_status <= res_status;
            r_obyte  <= res_byte;
            r_pos    <= POS_W'(n_pc);
        end
    end
endmodule

[hw/rtl/tlp_ram.sv]
module tlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/tlp_checker.sv]
`include "tape_language_processor_macros.svh"

module tlp_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [tlp_pkg::STATUS_W-1:0] i_status,
    input logic [tlp_pkg::BYTE_W-1:0]   i_out_byte,
    input logic [tlp_pkg::POS_W-1:0]    i_position
);
    import tlp_pkg::*;

    logic                                  stalled;
    logic                                  no_byte;
    logic [STATUS_W+BYTE_W+POS_W-1:0]      word;

    assign stalled = i_out_valid && !i_out_ready;
    assign no_byte = i_out_valid && (i_status != ST_BYTE);
    assign word    = {i_status, i_out_byte, i_position};

    // status codes stay within the defined set
    `TLP_ASSERT_IMP(a_status_range, i_clk, i_rst_n, i_out_valid, i_status <= ST_FULL, "bad status")

    // only an output command carries a byte
    `TLP_ASSERT_IMP(a_byte_zero, i_clk, i_rst_n, no_byte, i_out_byte == '0, "stray byte")

    // hold a stalled word
    `TLP_ASSERT_NXT(a_hold_valid, i_clk, i_rst_n, stalled, i_out_valid, "word dropped")

    `TLP_ASSERT_NXT(a_hold_data, i_clk, i_rst_n, stalled, $stable(word), "word changed")
endmodule

bind tape_language_processor tlp_checker u_tlp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_out_valid(o_out.valid),
    .i_out_ready(o_out.ready),
    .i_status   (o_out.status),
    .i_out_byte (o_out.out_byte),
    .i_position (o_out.position)
);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;
    import tlp_pkg::*;

    localparam int TAPE_N  = TAPE_DEPTH_DEF;
    localparam int PROG_N  = PROGRAM_DEPTH_DEF;
    localparam int NEST_N  = NEST_DEPTH_DEF;
    localparam int WDOG_MAX = 4 * TAPE_N + 20000;
    localparam int HOLD_LEN = 200;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SYM_W-1:0]  symbol;
    } t_word_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   out_byte;
        logic [POS_W-1:0]    position;
    } t_word_out;

    logic i_clk;
    logic i_rst_n;

    tlp_in_if  in_if ();
    tlp_out_if out_if ();

    tape_language_processor DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    // interpreter mirror state
    logic [2:0]  prog_mem [PROG_N];
    int          jump_mem [PROG_N];
    int          open_stack [NEST_N];
    int          nest_lvl;
    int          prog_len;
    logic [7:0]  tape_mem [TAPE_N];
    int          dptr;
    int          pc;
    t_mode       mode;
    logic        bfault;

    t_word_in    pending_words[$];
    t_word_out   expected_results[$];
    int          errors;
    int          idle_cycles;
    bit          hold_recv;

    // command characters indexed by command code
    logic [7:0] cmd_char [8] = '{8'h3C, 8'h3E, 8'h2E, 8'h2C, 8'h2B, 8'h2D, 8'h5B, 8'h5D};

    function automatic int code_of(logic [7:0] s);
        for (int k = 0; k < 8; k++)
            if (cmd_char[k] == s) return k;
        return -1;
    endfunction

    // compute the result word of one accepted item and update mirror state
    function automatic t_word_out interpret_word(t_word_in w);
        t_word_out r;
        int        code;
        int        nxt;
        int        open_at;
        r = '0;
        case (w.kind)
            K_LOAD: begin
                code = code_of(w.symbol);
                if (code >= 0) begin
                    mode = M_LOAD;
                    if (prog_len >= PROG_N) begin
                        r.status = ST_FULL;
                    end else begin
                        prog_mem[prog_len] = code[2:0];
                        if (code == C_OPEN) begin
                            if (nest_lvl < NEST_N) begin
                                open_stack[nest_lvl] = prog_len;
                                nest_lvl++;
                            end else begin
                                bfault = 1'b1;
                                r.status = ST_BRACKET;
                            end
                        end else if (code == C_CLOSE) begin
                            if (nest_lvl > 0) begin
                                nest_lvl--;
                                open_at = open_stack[nest_lvl];
                                jump_mem[prog_len] = open_at;
                                jump_mem[open_at] = prog_len;
                            end else begin
                                bfault = 1'b1;
                                r.status = ST_BRACKET;
                            end
                        end
                        prog_len++;
                    end
                end
            end
            K_START: begin
                for (int k = 0; k < TAPE_N; k++) tape_mem[k] = 8'h00;
                dptr = 0;
                pc = 0;
                if (bfault || nest_lvl != 0) begin
                    mode = M_LOAD;
                    r.status = ST_BRACKET;
                end else begin
                    mode = M_RUN;
                end
            end
            K_STEP: begin
                if (mode == M_WAIT) r.status = ST_WAIT;
                else if (mode != M_RUN) r.status = ST_HALT;
                else if (pc >= prog_len) begin
                    mode = M_HALT;
                    r.status = ST_HALT;
                end else begin
                    nxt = pc + 1;
                    case (t_cmd'(prog_mem[pc]))
                        C_LEFT:  dptr = (dptr + TAPE_N - 1) % TAPE_N;
                        C_RIGHT: dptr = (dptr + 1) % TAPE_N;
                        C_OUT: begin
                            r.status = ST_BYTE;
                            r.out_byte = tape_mem[dptr];
                        end
                        C_IN: begin
                            mode = M_WAIT;
                            r.status = ST_WAIT;
                            nxt = pc;
                        end
                        C_INC: tape_mem[dptr] = tape_mem[dptr] + 8'd1;
                        C_DEC: tape_mem[dptr] = tape_mem[dptr] - 8'd1;
                        C_OPEN:  if (tape_mem[dptr] == 0) nxt = jump_mem[pc] + 1;
                        default: if (tape_mem[dptr] != 0) nxt = jump_mem[pc] + 1;
                    endcase
                    pc = nxt;
                end
            end
            default: begin
                if (mode == M_WAIT) begin
                    tape_mem[dptr] = w.symbol;
                    pc++;
                    mode = M_RUN;
                end
            end
        endcase
        r.position = pc[POS_W-1:0];
        return r;
    endfunction

    function automatic void push_word(logic [KIND_W-1:0] k, logic [7:0] s);
        t_word_in w;
        w.kind = k;
        w.symbol = s;
        pending_words.push_back(w);
    endfunction

    function automatic void push_program(string p);
        for (int k = 0; k < p.len(); k++) push_word(K_LOAD, p[k]);
    endfunction

    // clock
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // note whether the offered word was taken at the last edge
    bit in_taken;
    always @(posedge i_clk) begin
        in_taken <= in_if.valid && in_if.ready;
    end

    // driver: bursts of words with random gaps
    int burst_left;
    int gap_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (in_if.valid && !in_taken) begin
            // hold the offered word
        end else begin
            if (in_if.valid) void'(pending_words.pop_front());
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_if.valid <= 1'b0;
            end else if (burst_left == 0) begin
                burst_left <= $urandom_range(1, 12);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                in_if.valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                burst_left <= burst_left - 1;
                in_if.valid <= 1'b1;
                in_if.kind <= pending_words[0].kind;
                in_if.symbol <= pending_words[0].symbol;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with a long hold-off when requested
    int stall_phase;
    int hold_cnt;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_phase <= 0;
            hold_cnt <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (!hold_recv) hold_cnt <= 0;
            else if (hold_cnt < HOLD_LEN) hold_cnt <= hold_cnt + 1;
            out_if.ready <= !(hold_recv && hold_cnt < HOLD_LEN) &&
                ((stall_phase[9:8] == 2'b00) || ($urandom_range(0, 3) != 0));
        end
    end

    // monitor: predict on input accept, check on output accept
    always @(posedge i_clk) begin
        t_word_out exp_w;
        t_word_in  acc;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                acc.kind = in_if.kind;
                acc.symbol = in_if.symbol;
                expected_results.push_back(interpret_word(acc));
            end
            if (out_if.valid && out_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result word status=%0d", out_if.status);
                    errors++;
                end else begin
                    exp_w = expected_results.pop_front();
                    if (out_if.status !== exp_w.status) begin
                        $error("status exp=%0d got=%0d", exp_w.status, out_if.status);
                        errors++;
                    end
                    if (out_if.out_byte !== exp_w.out_byte) begin
                        $error("out_byte exp=%0h got=%0h", exp_w.out_byte, out_if.out_byte);
                        errors++;
                    end
                    if (out_if.position !== exp_w.position) begin
                        $error("position exp=%0d got=%0d", exp_w.position, out_if.position);
                        errors++;
                    end
                end
            end
        end
    end

    // watchdog: count cycles with no accepted word
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // random well-formed program with balanced brackets and a few inputs
    function automatic void push_random_program(int len);
        int depth;
        int r;
        depth = 0;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 9);
            if (r == 0 && depth < 3) begin
                push_word(K_LOAD, 8'h5B);
                depth++;
            end else if (r == 1 && depth > 0) begin
                push_word(K_LOAD, 8'h5D);
                depth--;
            end else if (r == 2) begin
                push_word(K_LOAD, 8'h2D);
            end else begin
                push_word(K_LOAD, cmd_char[$urandom_range(0, 5)]);
            end
        end
        while (depth > 0) begin
            push_word(K_LOAD, 8'h5D);
            depth--;
        end
    endfunction

    task automatic wait_drain();
        while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int n;
        errors = 0;
        idle_cycles = 0;
        hold_recv = 1'b0;
        nest_lvl = 0;
        prog_len = 0;
        dptr = 0;
        pc = 0;
        mode = M_LOAD;
        bfault = 1'b0;
        for (int k = 0; k < TAPE_N; k++) tape_mem[k] = 8'h00;
        in_if.valid = 1'b0;
        in_if.kind = K_LOAD;
        in_if.symbol = 8'h00;
        out_if.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: steps before any program, supply when idle, ignored chars
        push_word(K_STEP, 8'hFF);
        push_word(K_SUPPLY, 8'hAA);
        push_word(K_LOAD, 8'h00);
        push_word(K_LOAD, 8'hFF);
        // wrap both ways, input, output, loop
        push_program("<+.>-.,.[-]");
        push_word(K_START, 8'h00);
        for (int k = 0; k < 9; k++) push_word(K_STEP, 8'h00);
        push_word(K_SUPPLY, 8'h55);
        push_word(K_STEP, 8'h00);
        repeat (8) push_word(K_STEP, 8'h00);
        wait_drain();

        // receiver holds off long while sender keeps offering
        hold_recv = 1'b1;
        repeat (30) push_word(K_STEP, 8'h00);
        wait_drain();
        hold_recv = 1'b0;

        // random: build programs and run them
        n = 0;
        while (n < 650) begin
            push_random_program($urandom_range(4, 14));
            push_word(K_START, 8'h00);
            repeat ($urandom_range(5, 40)) begin
                if ($urandom_range(0, 7) == 0) push_word(K_SUPPLY, 8'($urandom));
                else push_word(K_STEP, 8'($urandom));
                n++;
            end
            if ($urandom_range(0, 9) == 0) push_word(K_LOAD, 8'($urandom));
            n += 16;
            wait_drain();
        end

        // open left at start, unmatched close, then sticky fault
        push_word(K_LOAD, 8'h5B);
        push_word(K_START, 8'h00);
        push_word(K_LOAD, 8'h5D);
        push_word(K_LOAD, 8'h5D);
        push_word(K_START, 8'h00);
        push_word(K_STEP, 8'h00);
        wait_drain();

        repeat (50) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
